[sv/crdc_pkg.sv]
// ----------------------------------------------------------------------------
// crdc_pkg: shared definitions for the configuration ROM directory crawler
// Sizes, command and result codes, and the records passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package crdc_pkg;

   // Geometry of the remote ROM, the pending directory stack and the work queue.
   localparam int ROM_QUADLETS  = 256;
   localparam int STACK_DEPTH   = 16;
   localparam int QUEUE_DEPTH   = 2;

   // A cursor must hold every index up to and including ROM_QUADLETS.
   localparam int CURSOR_W      = $clog2(ROM_QUADLETS + 1);
   localparam int HEADER_SUM_W  = ((CURSOR_W > 16) ? CURSOR_W : 16) + 1;
   localparam int STACK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int STACK_COUNT_W = $clog2(STACK_DEPTH + 1);
   localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // A stacked entry's beyond-ROM test uses the low 24 bits of index plus quadlet.
   localparam int ENTRY_INDEX_W = 24;

   // Well-known quadlet positions: bus options and the start of the root directory.
   localparam int BUS_OPTIONS_INDEX = 2;
   localparam int ROOT_DIR_INDEX    = 5;

   // Request classes produced by the front end.
   localparam logic [1:0] CMD_START     = 2'd0;
   localparam logic [1:0] CMD_READ_OK   = 2'd1;
   localparam logic [1:0] CMD_READ_FAIL = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_READ = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] quadlet;
      logic        quadlet_zero;
   } item_type;

   typedef struct packed {
      logic                is_dir;
      logic                beyond_rom;
      logic [CURSOR_W-1:0] index;
   } stack_entry_type;

endpackage

`default_nettype wire

[sv/crdc_front.sv]
// ----------------------------------------------------------------------------
// crdc_front: request intake and classification
// Turns each accepted request into a classified item for the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crdc_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_action,
   input  wire logic              req_read_ok,
   input  wire logic [31:0]       req_quadlet,
   input  wire logic              queue_full,
   output logic                   push_valid,
   output crdc_pkg::item_type     push_item
);

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      if (!req_action) begin
         push_item.cmd = crdc_pkg::CMD_START;
      end else if (req_read_ok) begin
         push_item.cmd = crdc_pkg::CMD_READ_OK;
      end else begin
         push_item.cmd = crdc_pkg::CMD_READ_FAIL;
      end
      push_item.quadlet      = req_quadlet;
      push_item.quadlet_zero = (req_quadlet == 32'd0);
   end

endmodule

`default_nettype wire

[sv/crdc_queue.sv]
// ----------------------------------------------------------------------------
// crdc_queue: short work queue between front end and walker
// A small circular buffer of classified items with registered storage.
// ----------------------------------------------------------------------------
`default_nettype none

module crdc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire crdc_pkg::item_type  push_item,
   output logic                     full,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output crdc_pkg::item_type       pop_item
);

   crdc_pkg::item_type                       slot_ff [crdc_pkg::QUEUE_DEPTH];
   logic [crdc_pkg::QUEUE_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [crdc_pkg::QUEUE_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [crdc_pkg::QUEUE_COUNT_W-1:0]       count_ff, count_in;
   logic                                     do_push;
   logic                                     do_pop;

   assign full      = (count_ff == crdc_pkg::QUEUE_COUNT_W'(crdc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == crdc_pkg::QUEUE_PTR_W'(crdc_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + crdc_pkg::QUEUE_PTR_W'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == crdc_pkg::QUEUE_PTR_W'(crdc_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + crdc_pkg::QUEUE_PTR_W'(1);
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + crdc_pkg::QUEUE_COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - crdc_pkg::QUEUE_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[sv/crdc_back.sv]
// ----------------------------------------------------------------------------
// crdc_back: directory walker
// Executes one queued item per cycle against the walk state and the pending
// directory stack when not stalled, and holds results in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crdc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire crdc_pkg::item_type  item,
   output logic                     item_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_read_index,
   output logic [8:0]               rsp_rom_length,
   output logic [3:0]               rsp_max_record,
   output logic                     rsp_cycle_master_capable,
   output logic                     rsp_resource_manager_capable
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_BIB    = 2'd1;
   localparam logic [1:0] PH_HEADER = 2'd2;
   localparam logic [1:0] PH_ENTRY  = 2'd3;

   localparam int CW = crdc_pkg::CURSOR_W;
   localparam int SW = crdc_pkg::STACK_COUNT_W;

   logic [1:0]                        phase_ff, phase_in;
   logic [SW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     cursor_ff, cursor_in;
   logic [CW-1:0]                     dir_end_ff, dir_end_in;
   logic                              in_dir_ff, in_dir_in;
   logic [CW-1:0]                     walk_ff, walk_in;
   logic [3:0]                        max_record_ff, max_record_in;
   logic                              cmc_ff, cmc_in;
   logic                              rmc_ff, rmc_in;
   crdc_pkg::stack_entry_type         stack_ff [crdc_pkg::STACK_DEPTH];

   logic                              rsp_valid_ff;
   logic [1:0]                        kind_ff;
   logic [7:0]                        index_ff;
   logic [8:0]                        length_ff;
   logic [3:0]                        out_record_ff;
   logic                              out_cmc_ff;
   logic                              out_rmc_ff;

   logic                              fire;
   logic                              res_valid;
   logic [1:0]                        res_kind;
   logic [CW-1:0]                     res_index;
   logic                              finish;
   logic                              push_en;
   crdc_pkg::stack_entry_type         push_entry;
   crdc_pkg::stack_entry_type         pop_entry;
   logic [31:0]                       entry_sum;
   logic [crdc_pkg::HEADER_SUM_W-1:0] header_end;
   logic [CW-1:0]                     cursor_inc;
   logic [SW-1:0]                     count_dec;

   assign item_ready = !rsp_valid_ff || !rsp_stall;
   assign fire       = item_valid && item_ready;

   assign cursor_inc = cursor_ff + CW'(1);
   assign count_dec  = count_ff - SW'(1);
   assign entry_sum  = 32'(cursor_ff) + item.quadlet;
   assign header_end = crdc_pkg::HEADER_SUM_W'(cursor_ff)
                     + crdc_pkg::HEADER_SUM_W'(item.quadlet[31:16])
                     + crdc_pkg::HEADER_SUM_W'(1);

   always_comb begin
      push_entry.is_dir     = (entry_sum[31:30] == 2'b11);
      push_entry.beyond_rom = (entry_sum[crdc_pkg::ENTRY_INDEX_W-1:0]
                               >= crdc_pkg::ENTRY_INDEX_W'(crdc_pkg::ROM_QUADLETS));
      push_entry.index      = entry_sum[CW-1:0];
   end

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      dir_end_in    = dir_end_ff;
      in_dir_in     = in_dir_ff;
      walk_in       = walk_ff;
      max_record_in = max_record_ff;
      cmc_in        = cmc_ff;
      rmc_in        = rmc_ff;
      res_valid     = 1'b0;
      res_kind      = crdc_pkg::KIND_READ;
      res_index     = '0;
      finish        = 1'b0;
      push_en       = 1'b0;
      pop_entry     = stack_ff[count_dec[crdc_pkg::STACK_IDX_W-1:0]];

      if (fire) begin
         if (item.cmd == crdc_pkg::CMD_START) begin
            count_in   = '0;
            cursor_in  = '0;
            dir_end_in = '0;
            in_dir_in  = 1'b0;
            walk_in    = '0;
            phase_in   = PH_BIB;
            res_valid  = 1'b1;
         end else if (phase_ff != PH_IDLE) begin
            res_valid = 1'b1;
            if (item.cmd == crdc_pkg::CMD_READ_FAIL) begin
               res_kind = crdc_pkg::KIND_FAIL;
            end else begin
               case (phase_ff)
                  PH_BIB: begin
                     if (cursor_ff == '0 && item.quadlet_zero) begin
                        res_kind = crdc_pkg::KIND_FAIL;
                     end else begin
                        if (cursor_ff == CW'(crdc_pkg::BUS_OPTIONS_INDEX)) begin
                           max_record_in = item.quadlet[15:12];
                           cmc_in        = item.quadlet[30];
                           rmc_in        = item.quadlet[31];
                        end
                        if (cursor_inc < CW'(crdc_pkg::ROOT_DIR_INDEX)) begin
                           cursor_in = cursor_inc;
                           res_index = cursor_inc;
                        end else begin
                           // The root directory is walked straight away.
                           walk_in   = CW'(crdc_pkg::ROOT_DIR_INDEX);
                           count_in  = '0;
                           in_dir_in = 1'b1;
                           cursor_in = CW'(crdc_pkg::ROOT_DIR_INDEX);
                           phase_in  = PH_HEADER;
                           res_index = CW'(crdc_pkg::ROOT_DIR_INDEX);
                        end
                     end
                  end
                  PH_HEADER: begin
                     if (header_end
                         > crdc_pkg::HEADER_SUM_W'(crdc_pkg::ROM_QUADLETS)) begin
                        res_kind = crdc_pkg::KIND_FAIL;
                     end else begin
                        dir_end_in = header_end[CW-1:0];
                        cursor_in  = cursor_inc;
                        if (item.quadlet[31:16] != 16'd0) begin
                           phase_in  = PH_ENTRY;
                           res_index = cursor_inc;
                        end else begin
                           finish = 1'b1;
                        end
                     end
                  end
                  PH_ENTRY: begin
                     push_en = in_dir_ff && item.quadlet[31]
                            && (count_ff < SW'(crdc_pkg::STACK_DEPTH));
                     cursor_in = cursor_inc;
                     if (cursor_inc < dir_end_ff) begin
                        res_index = cursor_inc;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
            end
         end
      end

      if (push_en) begin
         count_in = count_ff + SW'(1);
      end

      // End of a directory: record its reach, then pop the next one, or report done.
      if (finish) begin
         if (walk_ff < cursor_inc) begin
            walk_in = cursor_inc;
         end
         if (count_ff == '0 && !push_en) begin
            res_kind = crdc_pkg::KIND_DONE;
         end else begin
            if (push_en) begin
               pop_entry = push_entry;
               count_in  = count_ff;
            end else begin
               count_in  = count_dec;
            end
            if (pop_entry.beyond_rom) begin
               res_kind = crdc_pkg::KIND_FAIL;
            end else begin
               in_dir_in = pop_entry.is_dir;
               cursor_in = pop_entry.index;
               phase_in  = PH_HEADER;
               res_index = pop_entry.index;
            end
         end
      end

      if (res_valid && res_kind != crdc_pkg::KIND_READ) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         cursor_ff     <= '0;
         dir_end_ff    <= '0;
         in_dir_ff     <= 1'b0;
         walk_ff       <= '0;
         max_record_ff <= '0;
         cmc_ff        <= 1'b0;
         rmc_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         cursor_ff     <= cursor_in;
         dir_end_ff    <= dir_end_in;
         in_dir_ff     <= in_dir_in;
         walk_ff       <= walk_in;
         max_record_ff <= max_record_in;
         cmc_ff        <= cmc_in;
         rmc_ff        <= rmc_in;
         if (fire && res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_ff[count_ff[crdc_pkg::STACK_IDX_W-1:0]] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         kind_ff       <= res_kind;
         index_ff      <= '0;
         length_ff     <= '0;
         out_record_ff <= '0;
         out_cmc_ff    <= 1'b0;
         out_rmc_ff    <= 1'b0;
         if (res_kind == crdc_pkg::KIND_READ) begin
            index_ff <= 8'(res_index);
         end else if (res_kind == crdc_pkg::KIND_DONE) begin
            length_ff     <= 9'(walk_in);
            out_record_ff <= max_record_in;
            out_cmc_ff    <= cmc_in;
            out_rmc_ff    <= rmc_in;
         end
      end
   end

   assign rsp_valid                    = rsp_valid_ff;
   assign rsp_kind                     = kind_ff;
   assign rsp_read_index               = index_ff;
   assign rsp_rom_length               = length_ff;
   assign rsp_max_record               = out_record_ff;
   assign rsp_cycle_master_capable     = out_cmc_ff;
   assign rsp_resource_manager_capable = out_rmc_ff;

endmodule

`default_nettype wire

[sv/config_rom_directory_crawler.sv]
// ----------------------------------------------------------------------------
// config_rom_directory_crawler: configuration ROM directory walk controller
// A request passes through a queue slot and then the walker output register.
// Throughput: one request and one walker item per cycle while not stalled.
// The pace is set by the walker step behind a two-entry queue.
// Reset is synchronous and leaves the walker idle with an empty queue.
// ----------------------------------------------------------------------------
`default_nettype none

module config_rom_directory_crawler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic        req_read_ok,
   input  wire logic [31:0] req_quadlet,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_read_index,
   output logic [8:0]       rsp_rom_length,
   output logic [3:0]       rsp_max_record,
   output logic             rsp_cycle_master_capable,
   output logic             rsp_resource_manager_capable
);

   // The front end classifies each request as a start, a good read or a
   // failed read, and precomputes the zero test on the returned quadlet.
   logic                 queue_full;
   logic                 push_valid;
   crdc_pkg::item_type   push_item;

   // The queue decouples intake from the walker, so a stalled result does
   // not immediately stall the request side.
   logic                 pop_valid;
   logic                 pop_ready;
   crdc_pkg::item_type   pop_item;

   crdc_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_read_ok (req_read_ok),
      .req_quadlet (req_quadlet),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   crdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // The walker holds the walk state and the stack of pending directories.
   // It takes an item whenever its output register is free or being drained,
   // and a directory that ends in the same step as a push pops that very
   // entry through a bypass rather than through the stack storage.
   crdc_back u_back (
      .clock                        (clock),
      .reset                        (reset),
      .item_valid                   (pop_valid),
      .item                         (pop_item),
      .item_ready                   (pop_ready),
      .rsp_valid                    (rsp_valid),
      .rsp_stall                    (rsp_stall),
      .rsp_kind                     (rsp_kind),
      .rsp_read_index               (rsp_read_index),
      .rsp_rom_length               (rsp_rom_length),
      .rsp_max_record               (rsp_max_record),
      .rsp_cycle_master_capable     (rsp_cycle_master_capable),
      .rsp_resource_manager_capable (rsp_resource_manager_capable)
   );

endmodule

`default_nettype wire
